@@ rtl/core/efe_pkg.sv @@
// Shared types, constants and helper functions of the exponential field evaluator.
`default_nettype none
package efe_pkg;

    localparam logic [2:0] REG_AMPLITUDE  = 3'd0;
    localparam logic [2:0] REG_DECAY_RATE = 3'd1;
    localparam logic [2:0] REG_EXP_OFFSET = 3'd2;
    localparam logic [2:0] REG_OFFSET_X   = 3'd3;
    localparam logic [2:0] REG_OFFSET_YZ  = 3'd4;
    localparam logic [2:0] REG_X_BOUNDS   = 3'd5;
    localparam logic [2:0] REG_Y_BOUNDS   = 3'd6;
    localparam logic [2:0] REG_Z_BOUNDS   = 3'd7;

    localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic [30:0] ONE_Q30 = 31'd1073741824;
    localparam logic signed [65:0] E_CLAMP = 66'sd274877906944;
    localparam logic [31:0] RECIP5 = 32'hCCCCCCCD;
    localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;

    typedef struct packed {
        logic [31:0] amplitude;
        logic [31:0] decay_rate;
        logic [31:0] exponent_offset;
        logic [31:0] offset_x_field;
        logic [31:0] offset_yz_field;
        logic [63:0] x_bounds;
        logic [63:0] y_bounds;
        logic [63:0] z_bounds;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               in_box;
    } item_t;

    function automatic logic [30:0] pow2_frac(input logic [1:0] j);
        logic [30:0] v;
        begin
            case (j)
                2'd0:    v = 31'd1073741824;
                2'd1:    v = 31'd1276901417;
                2'd2:    v = 31'd1518500250;
                default: v = 31'd1805811301;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [65:0] sx32(input logic [31:0] v);
        return {{34{v[31]}}, v};
    endfunction

    function automatic logic signed [65:0] sx64(input logic [63:0] v);
        return {{2{v[63]}}, v};
    endfunction

    function automatic logic [31:0] sat32(input logic signed [65:0] v);
        logic [31:0] r;
        begin
            if (v > 66'sd2147483647)
                r = 32'h7FFFFFFF;
            else if (v < -66'sd2147483648)
                r = 32'h80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/exp_field_eval_unit.sv @@
// Top level of the exponential field evaluator: configuration registers and wiring.
//
// Channel   Direction  Transfer condition     Payload
// --------  ---------  ---------------------  --------------------------------------
// query     in         start && !busy         pos_x, pos_y, pos_z
// result    out        done (one cycle)       field_x/y/z, grad_xx/yy/zz, inside_res
// config    in         cfg_we                 cfg_index, cfg_data
//
// One query is taken every cycle while busy is low.
// Each result passes through the front register, one queue slot and the 16-stage back end,
// which evaluates the exponential as a chain of pipelined multiplies.
// Reset clears the configuration registers to zero and empties the pipeline.
// The receiver cannot stall; busy rises only if the queue were to fill.
`default_nettype none
module exp_field_eval_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output      logic        busy,
    input  wire logic [31:0] pos_x,
    input  wire logic [31:0] pos_y,
    input  wire logic [31:0] pos_z,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    output      logic        done,
    output      logic [31:0] field_x,
    output      logic [31:0] field_y,
    output      logic [31:0] field_z,
    output      logic [31:0] grad_xx,
    output      logic [31:0] grad_yy,
    output      logic [31:0] grad_zz,
    output      logic        inside_res
);
    import efe_pkg::*;

    cfg_t  cfg_reg;
    logic  accept;
    logic  push;
    item_t f_item;
    logic  pop;
    item_t q_item;
    logic  full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_AMPLITUDE:  cfg_reg.amplitude       <= cfg_data[31:0];
                REG_DECAY_RATE: cfg_reg.decay_rate      <= cfg_data[31:0];
                REG_EXP_OFFSET: cfg_reg.exponent_offset <= cfg_data[31:0];
                REG_OFFSET_X:   cfg_reg.offset_x_field  <= cfg_data[31:0];
                REG_OFFSET_YZ:  cfg_reg.offset_yz_field <= cfg_data[31:0];
                REG_X_BOUNDS:   cfg_reg.x_bounds        <= cfg_data;
                REG_Y_BOUNDS:   cfg_reg.y_bounds        <= cfg_data;
                REG_Z_BOUNDS:   cfg_reg.z_bounds        <= cfg_data;
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign busy   = full;
    assign accept = start && !busy;

    efe_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .pos_x  (pos_x),
        .pos_y  (pos_y),
        .pos_z  (pos_z),
        .cfg    (cfg_reg),
        .push   (push),
        .item   (f_item)
    );

    efe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (f_item),
        .pop     (pop),
        .rd_item (q_item),
        .full    (full)
    );

    efe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_vld     (pop),
        .in_item    (q_item),
        .cfg        (cfg_reg),
        .done       (done),
        .field_x    (field_x),
        .field_y    (field_y),
        .field_z    (field_z),
        .grad_xx    (grad_xx),
        .grad_yy    (grad_yy),
        .grad_zz    (grad_zz),
        .inside_res (inside_res)
    );

`ifndef SYNTH
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("queue filled although the back end never stalls");
    a_grad_equal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (grad_yy == grad_zz))
        else $error("transverse gradients differ");
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##18 done)
        else $error("accepted query produced no result");
`endif

endmodule
`default_nettype wire

@@ rtl/core/efe_front.sv @@
// Front end: captures a query point and classifies it against the box.
`default_nettype none
module efe_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic [31:0]    pos_x,
    input  wire logic [31:0]    pos_y,
    input  wire logic [31:0]    pos_z,
    input  wire efe_pkg::cfg_t  cfg,
    output      logic           push,
    output      efe_pkg::item_t item
);
    import efe_pkg::*;

    logic  vld_reg;
    item_t itm_reg;
    logic  in_x;
    logic  in_y;
    logic  in_z;

    always_comb
    begin
        in_x = ($signed(pos_x) >= $signed(cfg.x_bounds[31:0])) &&
               ($signed(pos_x) <= $signed(cfg.x_bounds[63:32]));
        in_y = ($signed(pos_y) >= $signed(cfg.y_bounds[31:0])) &&
               ($signed(pos_y) <= $signed(cfg.y_bounds[63:32]));
        in_z = ($signed(pos_z) >= $signed(cfg.z_bounds[31:0])) &&
               ($signed(pos_z) <= $signed(cfg.z_bounds[63:32]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            itm_reg.x      <= $signed(pos_x);
            itm_reg.y      <= $signed(pos_y);
            itm_reg.z      <= $signed(pos_z);
            itm_reg.in_box <= in_x && in_y && in_z;
        end
    end

    assign push = vld_reg;
    assign item = itm_reg;

endmodule
`default_nettype wire

@@ rtl/core/efe_queue.sv @@
// Small queue between the classifying front end and the arithmetic back end.
`default_nettype none
module efe_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire efe_pkg::item_t wr_item,
    output      logic           pop,
    output      efe_pkg::item_t rd_item,
    output      logic           full
);
    import efe_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t          mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  cnt_next;

    // The back end never stalls, so anything stored leaves at once.
    assign pop     = (cnt_reg != '0);
    assign full    = (cnt_reg == CW'(DEPTH));
    assign rd_item = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_item;
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("transfer into a full queue");
    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count did not follow a transfer in");
`endif

endmodule
`default_nettype wire

@@ rtl/core/efe_back.sv @@
// Back end: pipelined exponential, scaling, gradients and field components.
`default_nettype none
module efe_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_vld,
    input  wire efe_pkg::item_t in_item,
    input  wire efe_pkg::cfg_t  cfg,
    output      logic           done,
    output      logic [31:0]    field_x,
    output      logic [31:0]    field_y,
    output      logic [31:0]    field_z,
    output      logic [31:0]    grad_xx,
    output      logic [31:0]    grad_yy,
    output      logic [31:0]    grad_zz,
    output      logic           inside_res
);
    import efe_pkg::*;

    localparam int NS = 16;

    logic         vld_reg [1:NS];
    item_t        itm_reg [1:NS];
    logic [7:0]   k_reg   [2:11];
    logic [1:0]   j_reg   [3:9];
    logic [27:0]  u_reg   [3:8];

    logic signed [31:0] e24_reg;
    logic [29:0]        f_reg;
    logic [30:0]        q1_reg;
    logic [28:0]        p1_reg;
    logic [28:0]        p2_reg;
    logic [30:0]        q3_reg;
    logic [28:0]        p3_reg;
    logic [28:0]        p4_reg;
    logic [31:0]        m_reg;
    logic [63:0]        prod_reg;
    logic [31:0]        s_reg;
    logic signed [63:0] as_reg;
    logic [31:0]        bx13_reg;
    logic [31:0]        bx14_reg;
    logic [31:0]        bx15_reg;
    logic [31:0]        gxx14_reg;
    logic [31:0]        gxx15_reg;
    logic [31:0]        g14_reg;
    logic [31:0]        g15_reg;
    logic signed [63:0] yg_reg;
    logic signed [63:0] zg_reg;
    logic [31:0]        fx_reg;
    logic [31:0]        fy_reg;
    logic [31:0]        fz_reg;
    logic [31:0]        gxx_reg;
    logic [31:0]        g_reg;

    logic signed [63:0] ax;
    logic signed [65:0] e_full;
    logic signed [65:0] e_cl;
    logic signed [63:0] t;
    logic [57:0]        uprod;
    logic [63:0]        d5;
    logic [63:0]        d3;
    logic [63:0]        pr5;
    logic [63:0]        pr6;
    logic [63:0]        pr8;
    logic [63:0]        pr9;
    logic [30:0]        q2;
    logic [30:0]        q4;
    logic [30:0]        q5;
    logic [61:0]        mprod;
    logic               a_neg;
    logic [31:0]        a_mag;
    logic [63:0]        lim;
    logic signed [8:0]  sh;
    logic [7:0]         n;
    logic [63:0]        rr;
    logic [31:0]        res;
    logic signed [65:0] gxx_v;
    logic signed [65:0] g_v;
    logic signed [65:0] by_v;
    logic signed [65:0] bz_v;

    assign a_neg = cfg.amplitude[31];
    assign a_mag = a_neg ? (32'd0 - cfg.amplitude) : cfg.amplitude;
    assign lim   = a_neg ? 64'h80000000 : 64'h7FFFFFFF;

    always_comb
    begin
        ax     = $signed(cfg.decay_rate) * in_item.x;
        e_full = {{18{cfg.exponent_offset[31]}}, cfg.exponent_offset, 16'd0} - sx64(ax);
        if (e_full > E_CLAMP)
            e_cl = E_CLAMP;
        else if (e_full < -E_CLAMP)
            e_cl = -E_CLAMP;
        else
            e_cl = e_full;

        t     = e24_reg * LOG2E_Q30;
        uprod = f_reg[27:0] * LN2_Q30;
        d5    = 64'(u_reg[3]) * 64'(RECIP5);
        pr5   = 64'(u_reg[4]) * 64'(q1_reg);
        q2    = ONE_Q30 + 31'(p1_reg >> 2);
        pr6   = 64'(u_reg[5]) * 64'(q2);
        d3    = 64'(p2_reg) * 64'(RECIP3);
        pr8   = 64'(u_reg[7]) * 64'(q3_reg);
        q4    = ONE_Q30 + 31'(p3_reg >> 1);
        pr9   = 64'(u_reg[8]) * 64'(q4);
        q5    = ONE_Q30 + 31'(p4_reg);
        mprod = 62'(pow2_frac(j_reg[9])) * 62'(q5);

        // Scale the product by 2^(k-30): saturate on the left, round on the right.
        sh  = $signed({k_reg[11][7], k_reg[11]}) - 9'sd30;
        n   = 8'(-sh);
        rr  = '0;
        res = '0;
        if (!sh[8])
        begin
            if (prod_reg != 64'd0 && (sh >= 9'sd32 || prod_reg > (lim >> sh[4:0])))
                res = lim[31:0];
            else
                res = 32'(prod_reg << sh[4:0]);
        end
        else if (n < 8'd63)
        begin
            rr  = (prod_reg + (64'd1 << (n[5:0] - 6'd1))) >> n[5:0];
            res = (rr > lim) ? lim[31:0] : rr[31:0];
        end

        gxx_v = (-sx64(as_reg) + 66'sd32768) >>> 16;
        g_v   = (sx64(as_reg) + 66'sd65536) >>> 17;
        by_v  = ((sx64(yg_reg) + 66'sd32768) >>> 16) + sx32(cfg.offset_yz_field);
        bz_v  = ((sx64(zg_reg) + 66'sd32768) >>> 16) + sx32(cfg.offset_yz_field);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= NS; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            vld_reg[1] <= in_vld;
            for (int i = 2; i <= NS; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        itm_reg[1] <= in_item;
        for (int i = 2; i <= NS; i++)
            itm_reg[i] <= itm_reg[i-1];
        for (int i = 3; i <= 11; i++)
            k_reg[i] <= k_reg[i-1];
        for (int i = 4; i <= 9; i++)
            j_reg[i] <= j_reg[i-1];
        for (int i = 4; i <= 8; i++)
            u_reg[i] <= u_reg[i-1];

        e24_reg <= e_cl[39:8];
        k_reg[2] <= t[61:54];
        f_reg    <= t[53:24];
        u_reg[3] <= uprod[57:30];
        j_reg[3] <= f_reg[29:28];
        q1_reg <= ONE_Q30 + 31'(d5[61:34]);
        p1_reg <= pr5[58:30];
        p2_reg <= pr6[58:30];
        q3_reg <= ONE_Q30 + 31'(d3[60:33]);
        p3_reg <= pr8[58:30];
        p4_reg <= pr9[58:30];
        m_reg  <= mprod[61:30];
        prod_reg <= 64'(a_mag) * 64'(m_reg);
        s_reg <= a_neg ? (32'd0 - res) : res;
        as_reg   <= $signed(cfg.decay_rate) * $signed(s_reg);
        bx13_reg <= sat32(sx32(s_reg) + sx32(cfg.offset_x_field));
        gxx14_reg <= sat32(gxx_v);
        g14_reg   <= sat32(g_v);
        bx14_reg  <= bx13_reg;
        yg_reg    <= itm_reg[14].y * $signed(g14_reg);
        zg_reg    <= itm_reg[14].z * $signed(g14_reg);
        bx15_reg  <= bx14_reg;
        gxx15_reg <= gxx14_reg;
        g15_reg   <= g14_reg;
        fx_reg  <= itm_reg[15].in_box ? bx15_reg : 32'd0;
        fy_reg  <= itm_reg[15].in_box ? sat32(by_v) : 32'd0;
        fz_reg  <= itm_reg[15].in_box ? sat32(bz_v) : 32'd0;
        gxx_reg <= itm_reg[15].in_box ? gxx15_reg : 32'd0;
        g_reg   <= itm_reg[15].in_box ? g15_reg : 32'd0;
    end

    assign done       = vld_reg[NS];
    assign field_x    = fx_reg;
    assign field_y    = fy_reg;
    assign field_z    = fz_reg;
    assign grad_xx    = gxx_reg;
    assign grad_yy    = g_reg;
    assign grad_zz    = g_reg;
    assign inside_res = itm_reg[NS].in_box;

`ifndef SYNTH
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !inside_res) |-> (field_x == 32'd0 && field_y == 32'd0 &&
                                   field_z == 32'd0 && grad_xx == 32'd0))
        else $error("result outside the box carries nonzero field");
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld |-> ##16 done)
        else $error("back end lost an item");
    a_zero_amp: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[12] && cfg.amplitude == 32'd0) |-> (s_reg == 32'd0))
        else $error("zero amplitude gave nonzero scale");
`endif

endmodule
`default_nettype wire

@@ verif/efe_checker.sv @@
// Checker for the exponential field evaluator: predicts each result and compares it.
`timescale 1ns / 1ps
module efe_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [31:0] pos_x,
    input  wire logic [31:0] pos_y,
    input  wire logic [31:0] pos_z,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        done,
    input  wire logic [31:0] field_x,
    input  wire logic [31:0] field_y,
    input  wire logic [31:0] field_z,
    input  wire logic [31:0] grad_xx,
    input  wire logic [31:0] grad_yy,
    input  wire logic [31:0] grad_zz,
    input  wire logic        inside_res,
    output int               errors,
    output int               pending,
    output int               results_seen,
    output int               inside_seen
);
    import efe_pkg::*;

    typedef struct packed {
        logic [31:0] bx;
        logic [31:0] by;
        logic [31:0] bz;
        logic [31:0] gxx;
        logic [31:0] gyy;
        logic [31:0] gzz;
        logic        in_box;
    } field_sample_t;

    localparam longint EXP_LIMIT = 64'sd274877906944;
    localparam longint LOG2E = 64'sd1549082005;
    localparam longint unsigned LN2 = 64'd744261118;
    localparam longint unsigned ONE = 64'd1073741824;

    cfg_t          shadow_cfg;
    field_sample_t field_queue[$];

    function automatic longint sx(input logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint clip32(input longint v);
        longint r;
        begin
            r = v;
            if (v > 64'sd2147483647)
                r = 64'sd2147483647;
            else if (v < -64'sd2147483648)
                r = -64'sd2147483648;
            return r;
        end
    endfunction

    // Round half up, then drop n fraction bits.
    function automatic longint round_shift(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint unsigned frac_pow2(input longint unsigned j);
        longint unsigned v;
        begin
            case (j)
                0:       v = 64'd1073741824;
                1:       v = 64'd1276901417;
                2:       v = 64'd1518500250;
                default: v = 64'd1805811301;
            endcase
            return v;
        end
    endfunction

    // a1 * exp(e) with e in Q32.32; result Q16.16, saturated.
    function automatic longint scaled_exponential(input longint a1, input longint e_in);
        longint e, e24, t, k, sh, n;
        longint unsigned f, r, u, q, m, mag, p, lim, res;
        begin
            e = e_in;
            if (e > EXP_LIMIT) e = EXP_LIMIT;
            if (e < -EXP_LIMIT) e = -EXP_LIMIT;
            e24 = e >>> 8;
            t = e24 * LOG2E;
            k = t >>> 54;
            f = (longint'(unsigned'(t)) & 64'h003F_FFFF_FFFF_FFFF) >> 24;
            f = f & 64'h3FFF_FFFF;
            r = f & 64'h0FFF_FFFF;
            u = (r * LN2) >> 30;
            q = ONE + u / 5;
            q = ONE + ((u * q) >> 30) / 4;
            q = ONE + ((u * q) >> 30) / 3;
            q = ONE + ((u * q) >> 30) / 2;
            q = ONE + ((u * q) >> 30);
            m = (frac_pow2((f >> 28) & 3) * q) >> 30;
            mag = (a1 < 0) ? longint'(-a1) : longint'(a1);
            p = mag * m;
            lim = (a1 < 0) ? 64'd2147483648 : 64'd2147483647;
            sh = k - 30;
            if (sh >= 0) begin
                if (p != 0 && (sh >= 32 || p > (lim >> sh)))
                    res = lim;
                else
                    res = p << sh;
            end else begin
                n = -sh;
                if (n >= 63)
                    res = 0;
                else
                    res = (p + (64'd1 << (n - 1))) >> n;
                if (res > lim) res = lim;
            end
            return (a1 < 0) ? -longint'(res) : longint'(res);
        end
    endfunction

    function automatic bit in_span(input longint p, input logic [63:0] span);
        return p >= sx(span[31:0]) && p <= sx(span[63:32]);
    endfunction

    function automatic field_sample_t evaluate_field(input cfg_t c, input logic [31:0] px,
                                                     input logic [31:0] py,
                                                     input logic [31:0] pz);
        field_sample_t o;
        longint x, y, z, s, as_prod, g;
        begin
            x = sx(px);
            y = sx(py);
            z = sx(pz);
            o = '0;
            if (in_span(x, c.x_bounds) && in_span(y, c.y_bounds) && in_span(z, c.z_bounds)) begin
                s = scaled_exponential(sx(c.amplitude),
                                       sx(c.exponent_offset) * 65536 - sx(c.decay_rate) * x);
                as_prod = sx(c.decay_rate) * s;
                g = clip32(round_shift(as_prod, 17));
                o.bx = 32'(clip32(s + sx(c.offset_x_field)));
                o.gxx = 32'(clip32(round_shift(-as_prod, 16)));
                o.gyy = 32'(g);
                o.gzz = 32'(g);
                o.by = 32'(clip32(round_shift(y * g, 16) + sx(c.offset_yz_field)));
                o.bz = 32'(clip32(round_shift(z * g, 16) + sx(c.offset_yz_field)));
                o.in_box = 1'b1;
            end
            return o;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n) begin
        field_sample_t want, got;
        if (!rst_n) begin
            shadow_cfg <= '0;
            errors <= 0;
            results_seen <= 0;
            inside_seen <= 0;
            field_queue.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_AMPLITUDE:  shadow_cfg.amplitude <= cfg_data[31:0];
                    REG_DECAY_RATE: shadow_cfg.decay_rate <= cfg_data[31:0];
                    REG_EXP_OFFSET: shadow_cfg.exponent_offset <= cfg_data[31:0];
                    REG_OFFSET_X:   shadow_cfg.offset_x_field <= cfg_data[31:0];
                    REG_OFFSET_YZ:  shadow_cfg.offset_yz_field <= cfg_data[31:0];
                    REG_X_BOUNDS:   shadow_cfg.x_bounds <= cfg_data;
                    REG_Y_BOUNDS:   shadow_cfg.y_bounds <= cfg_data;
                    REG_Z_BOUNDS:   shadow_cfg.z_bounds <= cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                field_queue.push_back(evaluate_field(shadow_cfg, pos_x, pos_y, pos_z));
            if (done) begin
                got = {field_x, field_y, field_z, grad_xx, grad_yy, grad_zz, inside_res};
                results_seen <= results_seen + 1;
                if (inside_res) inside_seen <= inside_seen + 1;
                if (field_queue.size() == 0) begin
                    if (errors < 10)
                        $display("checker: result with nothing expected: %h", got);
                    errors <= errors + 1;
                end else begin
                    want = field_queue.pop_front();
                    if (want !== got) begin
                        if (errors < 10) begin
                            $display("checker: mismatch bx %h/%h by %h/%h bz %h/%h",
                                     want.bx, got.bx, want.by, got.by, want.bz, got.bz);
                            $display("checker:   gxx %h/%h gyy %h/%h gzz %h/%h in %b/%b",
                                     want.gxx, got.gxx, want.gyy, got.gyy,
                                     want.gzz, got.gzz, want.in_box, got.in_box);
                        end
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

    // The queue changes at the edge itself, so every transfer already taken is counted.
    assign pending = field_queue.size();

endmodule

@@ verif/tb.sv @@
// Testbench top for the exponential field evaluator: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module tb;
    import efe_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        done;
    logic [31:0] field_x, field_y, field_z, grad_xx, grad_yy, grad_zz;
    logic        inside_res;
    int          errors, pending, results_seen, inside_seen;
    int          idle_cycles = 0;
    int          settings_run = 0;
    longint      x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;

    always #5 clk = ~clk;

    exp_field_eval_unit i_dut (.*);
    efe_checker i_checker (.*);

    always @(posedge clk) begin
        if ((start && !busy) || done || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        int gap;
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            start <= 1'b1;
            pos_x <= x;
            pos_y <= y;
            pos_z <= z;
            // busy is stable at the falling edge; low there means a transfer at the next rise.
            do @(negedge clk); while (busy);
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= value;
            @(posedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    task automatic apply_settings(input logic [31:0] a1, input logic [31:0] a2,
                                  input logic [31:0] a3, input logic [31:0] c1,
                                  input logic [31:0] c2, input logic [63:0] xb,
                                  input logic [63:0] yb, input logic [63:0] zb);
        begin
            start <= 1'b0;
            @(posedge clk);
            wait (pending == 0);
            repeat (DRAIN_CYCLES) @(posedge clk);
            write_reg(REG_AMPLITUDE, {32'd0, a1});
            write_reg(REG_DECAY_RATE, {32'd0, a2});
            write_reg(REG_EXP_OFFSET, {32'd0, a3});
            write_reg(REG_OFFSET_X, {32'd0, c1});
            write_reg(REG_OFFSET_YZ, {32'd0, c2});
            write_reg(REG_X_BOUNDS, xb);
            write_reg(REG_Y_BOUNDS, yb);
            write_reg(REG_Z_BOUNDS, zb);
            x_lo = longint'($signed(xb[31:0]));
            x_hi = longint'($signed(xb[63:32]));
            y_lo = longint'($signed(yb[31:0]));
            y_hi = longint'($signed(yb[63:32]));
            z_lo = longint'($signed(zb[31:0]));
            z_hi = longint'($signed(zb[63:32]));
            settings_run++;
        end
    endtask

    function automatic logic [31:0] pick_in(input longint lo, input longint hi);
        longint span;
        begin
            if (hi < lo) return $urandom;
            span = hi - lo + 1;
            return 32'(lo + longint'({$urandom, $urandom} % span));
        end
    endfunction

    function automatic logic [31:0] rand_q(input int whole_max);
        return $urandom_range(0, 1) ? $urandom_range(0, whole_max << 16)
                                    : -$urandom_range(0, whole_max << 16);
    endfunction

    // Corner points of the box, the points just beyond it, and two points at the extremes of the signed range.
    task automatic edge_points();
        begin
            send_point(32'(x_lo), 32'(y_lo), 32'(z_lo));
            send_point(32'(x_hi), 32'(y_hi), 32'(z_hi));
            send_point(32'(x_lo), 32'(y_hi), 32'(z_lo));
            send_point(32'(x_lo - 1), 32'(y_lo), 32'(z_lo));
            send_point(32'(x_hi + 1), 32'(y_hi), 32'(z_hi));
            send_point(32'(x_lo), 32'(y_lo - 1), 32'(z_lo));
            send_point(32'(x_lo), 32'(y_lo), 32'(z_hi + 1));
            send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
            send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        end
    endtask

    task automatic random_points(input int count);
        begin
            repeat (count) begin
                if ($urandom_range(0, 4) != 0)
                    send_point(pick_in(x_lo, x_hi), pick_in(y_lo, y_hi), pick_in(z_lo, z_hi));
                else
                    send_point($urandom, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        logic [31:0] lo, hi;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset bounds are all zero, so only the origin lies inside.
        send_point(0, 0, 0);
        send_point(1, 0, 0);
        send_point(0, 32'hFFFF_FFFF, 0);

        apply_settings(32'h0001_0000, 32'h0000_8000, 0, 32'h0000_4000, 32'hFFFF_C000,
                       {32'h000A_0000, 32'hFFF6_0000}, {32'h000A_0000, 32'hFFF6_0000},
                       {32'h000A_0000, 32'hFFF6_0000});
        edge_points();
        random_points(150);

        apply_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h7FFF_FFFF, {32'h7FFF_FFFF, 32'h8000_0000},
                       {32'h7FFF_FFFF, 32'h8000_0000}, {32'h7FFF_FFFF, 32'h8000_0000});
        edge_points();
        random_points(80);

        apply_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h8000_0000, {32'h7FFF_FFFF, 32'h8000_0000},
                       {32'h7FFF_FFFF, 32'h8000_0000}, {32'h7FFF_FFFF, 32'h8000_0000});
        edge_points();
        random_points(80);

        // Zero amplitude leaves only the offsets; in the setting after it the inverted z range admits nothing.
        apply_settings(0, 32'h0002_0000, 32'h0001_0000, 32'h1234_5678, 32'hEDCB_A988,
                       {32'h0010_0000, 32'hFFF0_0000}, {32'h0010_0000, 32'hFFF0_0000},
                       {32'h0010_0000, 32'hFFF0_0000});
        edge_points();
        random_points(60);
        apply_settings(32'h0003_0000, 32'h0001_0000, 0, 0, 0,
                       {32'h0010_0000, 32'hFFF0_0000}, {32'h0010_0000, 32'hFFF0_0000},
                       {32'hFFF0_0000, 32'h0010_0000});
        edge_points();
        random_points(60);

        repeat (9) begin
            lo = rand_q($urandom_range(1, 60));
            hi = rand_q($urandom_range(1, 60));
            if ($signed(lo) > $signed(hi) && $urandom_range(0, 5) != 0)
                {lo, hi} = {hi, lo};
            apply_settings($urandom_range(0, 3) == 0 ? $urandom : rand_q(200),
                           $urandom_range(0, 3) == 0 ? $urandom : rand_q(4),
                           $urandom_range(0, 3) == 0 ? $urandom : rand_q(8),
                           $urandom_range(0, 1) ? $urandom : rand_q(100),
                           $urandom_range(0, 1) ? $urandom : rand_q(100),
                           {hi, lo}, {rand_q(500), -rand_q(500) & 32'hFFFF_FFFF | 32'h8000_0000},
                           {32'h7FFF_FFFF, 32'h8000_0000});
            if ($urandom_range(0, 1)) begin
                write_reg(REG_Y_BOUNDS, {32'h0040_0000, 32'hFFC0_0000});
                y_lo = -64'sd4194304;
                y_hi = 64'sd4194304;
            end
            edge_points();
            random_points(110);
        end

        start <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("tb: %0d results checked over %0d register settings, %0d inside the box",
                 results_seen, settings_run, inside_seen);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
